// ----- hdl/mfre_pkg.sv -----
`default_nettype none

package mfre_pkg;

  // Default panel geometry.
  localparam int DEF_PANEL_WIDTH  = 800;
  localparam int DEF_PANEL_HEIGHT = 480;

  // Internal coordinate, error-term and squared-distance widths.
  localparam int CW  = 16;
  localparam int EW  = 18;
  localparam int SQW = 24;

  localparam logic [7:0] BYTE_WHITE = 8'hFF;
  localparam logic [7:0] BYTE_BLACK = 8'h00;
  localparam logic [7:0] PIXEL_MSB  = 8'h80;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_PIXEL  = 3'd1,
    CMD_LINE   = 3'd2,
    CMD_RECT   = 3'd3,
    CMD_FILL   = 3'd4,
    CMD_CIRCLE = 3'd5,
    CMD_DISC   = 3'd6,
    CMD_READ   = 3'd7
  } cmd_t;

  // Drawing request handed to the shape walker.
  typedef struct packed {
    cmd_t               cmd;
    logic signed [12:0] xs;
    logic signed [12:0] ys;
    logic signed [12:0] xe;
    logic signed [12:0] ye;
    logic [11:0]        w;
    logic [11:0]        h;
    logic [10:0]        r;
  } draw_req_t;

  // Pixel offered by the walker, with its busy status.
  typedef struct packed {
    logic   valid;
    logic   busy;
    coord_t x;
    coord_t y;
  } px_t;

  typedef enum logic [2:0] {
    T_INIT,
    T_IDLE,
    T_CLEAR,
    T_DRAW,
    T_READ,
    T_DONE
  } top_state_t;

  typedef enum logic [3:0] {
    W_IDLE,
    W_PIXEL,
    W_LSET,
    W_LRUN,
    W_FSET,
    W_FRUN,
    W_CPTS,
    W_CSTEP,
    W_DSET,
    W_DCHK,
    W_DSQY,
    W_DSQX,
    W_DRUN
  } wk_state_t;

  // Bit reversal of one byte.
  function automatic logic [7:0] flip_byte(input logic [7:0] b);
    logic [7:0] o;
    for (int i = 0; i < 8; i++) begin
      o[i] = b[7-i];
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mfre_if.sv -----
`default_nettype none

// Request channel.
interface mfre_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [12:0] x_start;
  logic signed [12:0] y_start;
  logic signed [12:0] x_end;
  logic signed [12:0] y_end;
  logic [11:0]        rect_width;
  logic [11:0]        rect_height;
  logic [10:0]        radius;
  logic               ink;
  logic [8:0]         read_row;
  logic [6:0]         read_column;

  modport source (output valid, cmd, x_start, y_start, x_end, y_end, rect_width,
                  rect_height, radius, ink, read_row, read_column, input ready);
  modport sink (input valid, cmd, x_start, y_start, x_end, y_end, rect_width,
                rect_height, radius, ink, read_row, read_column, output ready);
endinterface

// Result channel.
interface mfre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       read_out_of_range;
  logic [2:0] done_cmd;

  modport source (output valid, read_byte, read_out_of_range, done_cmd, input ready);
  modport sink (input valid, read_byte, read_out_of_range, done_cmd, output ready);
endinterface

`default_nettype wire

// ----- hdl/mfre_ram.sv -----
`default_nettype none

module mfre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/mfre_walker.sv -----
`default_nettype none

module mfre_walker #(
  parameter int PANEL_WIDTH  = mfre_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = mfre_pkg::DEF_PANEL_HEIGHT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire mfre_pkg::draw_req_t req,
  input  wire logic                take,
  output mfre_pkg::px_t            px
);

  localparam int CW  = mfre_pkg::CW;
  localparam int EW  = mfre_pkg::EW;
  localparam int SQW = mfre_pkg::SQW;

  // Unit step for coordinates.
  localparam mfre_pkg::coord_t C_ONE = mfre_pkg::coord_t'(1);

  mfre_pkg::wk_state_t state_r, state_nxt;
  mfre_pkg::coord_t x_r, x_nxt, y_r, y_nxt, xb_r, xb_nxt, yb_r, yb_nxt;
  mfre_pkg::coord_t ax_r, ax_nxt, ay_r, ay_nxt, ex_r, ex_nxt, ey_r, ey_nxt;
  mfre_pkg::coord_t xl_r, xl_nxt, xh_r, xh_nxt, yl_r, yl_nxt, yh_r, yh_nxt;
  logic signed [EW-1:0] dx_r, dx_nxt, dy_r, dy_nxt, err_r, err_nxt;
  logic signed [EW-1:0] f_r, f_nxt, ddx_r, ddx_nxt, ddy_r, ddy_nxt;
  logic sxn_r, sxn_nxt, syn_r, syn_nxt, line_r, line_nxt;
  logic [1:0] seg_r, seg_nxt, last_seg_r, last_seg_nxt;
  logic [2:0] k_r, k_nxt;
  logic [10:0] rad_r, rad_nxt;
  logic [SQW-1:0] rr_r, rr_nxt, xsq_r, xsq_nxt, ysq_r, ysq_nxt, xlsq_r, xlsq_nxt;

  // Shared squaring multiplier for the disc setup.
  mfre_pkg::coord_t mul_op;
  logic signed [2*CW-1:0] mul_p;
  logic [SQW-1:0] sq;

  mfre_pkg::coord_t la_x, la_y, lb_x, lb_y, ldx, ldy, rad_c;
  logic signed [EW-1:0] e2;
  logic cond_x, cond_y, in_disc;
  mfre_pkg::coord_t f_xl, f_xh, f_yl, f_yh, d_xl, d_xh, d_yl, d_yh;
  mfre_pkg::coord_t c_a, c_b;
  logic signed [EW-1:0] c_ddy, c_f1, c_ddx;

  function automatic logic [SQW-1:0] sq_step(input mfre_pkg::coord_t v);
    logic signed [CW:0] t;
    t = $signed({v, 1'b1});
    return SQW'(t);
  endfunction

  always_comb begin
    case (state_r)
      mfre_pkg::W_DSET: mul_op = rad_c;
      mfre_pkg::W_DSQY: mul_op = yl_r;
      default:          mul_op = xl_r;
    endcase
    mul_p = mul_op * mul_op;
    sq    = mul_p[SQW-1:0];
  end

  // Segment end points: a plain line, or one of the four rectangle edges.
  always_comb begin
    la_x = ax_r;
    la_y = ay_r;
    lb_x = ex_r;
    lb_y = line_r ? ey_r : ay_r;
    case (seg_r)
      2'd1: begin
        la_y = ey_r;
        lb_y = ey_r;
      end
      2'd2: begin
        lb_x = ax_r;
        lb_y = ey_r;
      end
      2'd3: begin
        la_x = ex_r;
        lb_y = ey_r;
      end
      default: ;
    endcase
    ldx = lb_x - la_x;
    ldy = lb_y - la_y;
  end

  // Clip bounds for the filled shapes.
  always_comb begin
    rad_c = mfre_pkg::coord_t'(rad_r);
    f_xl  = (ax_r < 0) ? '0 : ax_r;
    f_yl  = (ay_r < 0) ? '0 : ay_r;
    f_xh  = (ex_r >= mfre_pkg::coord_t'(PANEL_WIDTH)) ?
            mfre_pkg::coord_t'(PANEL_WIDTH - 1) : ex_r;
    f_yh  = (ey_r >= mfre_pkg::coord_t'(PANEL_HEIGHT)) ?
            mfre_pkg::coord_t'(PANEL_HEIGHT - 1) : ey_r;
    d_xl  = (ax_r - rad_c < 0) ? -ax_r : -rad_c;
    d_yl  = (ay_r - rad_c < 0) ? -ay_r : -rad_c;
    d_xh  = (ax_r + rad_c > mfre_pkg::coord_t'(PANEL_WIDTH - 1)) ?
            mfre_pkg::coord_t'(PANEL_WIDTH - 1) - ax_r : rad_c;
    d_yh  = (ay_r + rad_c > mfre_pkg::coord_t'(PANEL_HEIGHT - 1)) ?
            mfre_pkg::coord_t'(PANEL_HEIGHT - 1) - ay_r : rad_c;
  end

  // Bresenham and midpoint step terms.
  always_comb begin
    e2      = err_r <<< 1;
    cond_x  = (e2 >= dy_r);
    cond_y  = (e2 <= dx_r);
    c_ddy   = (f_r >= 0) ? ddy_r + EW'(2) : ddy_r;
    c_f1    = (f_r >= 0) ? f_r + c_ddy : f_r;
    c_ddx   = ddx_r + EW'(2);
    in_disc = ({1'b0, xsq_r} + {1'b0, ysq_r}) <= {1'b0, rr_r};
    c_a     = k_r[2] ? y_r : x_r;
    c_b     = k_r[2] ? x_r : y_r;
  end

  // Pixel offered to the read-modify-write unit.
  always_comb begin
    px.busy  = (state_r != mfre_pkg::W_IDLE);
    px.valid = 1'b0;
    px.x     = x_r;
    px.y     = y_r;
    case (state_r)
      mfre_pkg::W_PIXEL, mfre_pkg::W_LRUN, mfre_pkg::W_FRUN: px.valid = 1'b1;
      mfre_pkg::W_CPTS: begin
        px.valid = 1'b1;
        px.x     = ax_r + (k_r[0] ? -c_a : c_a);
        px.y     = ay_r + (k_r[1] ? -c_b : c_b);
      end
      mfre_pkg::W_DRUN: begin
        px.valid = in_disc;
        px.x     = ax_r + x_r;
        px.y     = ay_r + y_r;
      end
      default: ;
    endcase
  end

  // Walker sequencing.
  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;  y_nxt = y_r;  xb_nxt = xb_r;  yb_nxt = yb_r;
    ax_nxt = ax_r;  ay_nxt = ay_r;  ex_nxt = ex_r;  ey_nxt = ey_r;
    xl_nxt = xl_r;  xh_nxt = xh_r;  yl_nxt = yl_r;  yh_nxt = yh_r;
    dx_nxt = dx_r;  dy_nxt = dy_r;  err_nxt = err_r;
    f_nxt = f_r;  ddx_nxt = ddx_r;  ddy_nxt = ddy_r;
    sxn_nxt = sxn_r;  syn_nxt = syn_r;  line_nxt = line_r;
    seg_nxt = seg_r;  last_seg_nxt = last_seg_r;  k_nxt = k_r;  rad_nxt = rad_r;
    rr_nxt = rr_r;  xsq_nxt = xsq_r;  ysq_nxt = ysq_r;  xlsq_nxt = xlsq_r;
    case (state_r)
      mfre_pkg::W_IDLE: begin
        if (start) begin
          ax_nxt       = mfre_pkg::coord_t'(req.xs);
          ay_nxt       = mfre_pkg::coord_t'(req.ys);
          rad_nxt      = req.r;
          seg_nxt      = 2'd0;
          line_nxt     = (req.cmd == mfre_pkg::CMD_LINE);
          last_seg_nxt = (req.cmd == mfre_pkg::CMD_RECT) ? 2'd3 : 2'd0;
          x_nxt        = mfre_pkg::coord_t'(req.xs);
          y_nxt        = mfre_pkg::coord_t'(req.ys);
          if (req.cmd == mfre_pkg::CMD_LINE) begin
            ex_nxt = mfre_pkg::coord_t'(req.xe);
            ey_nxt = mfre_pkg::coord_t'(req.ye);
          end else begin
            ex_nxt = mfre_pkg::coord_t'(req.xs) + mfre_pkg::coord_t'(req.w) - C_ONE;
            ey_nxt = mfre_pkg::coord_t'(req.ys) + mfre_pkg::coord_t'(req.h) - C_ONE;
          end
          case (req.cmd)
            mfre_pkg::CMD_PIXEL: state_nxt = mfre_pkg::W_PIXEL;
            mfre_pkg::CMD_LINE, mfre_pkg::CMD_RECT: state_nxt = mfre_pkg::W_LSET;
            mfre_pkg::CMD_FILL: state_nxt = mfre_pkg::W_FSET;
            mfre_pkg::CMD_CIRCLE: begin
              x_nxt     = '0;
              y_nxt     = mfre_pkg::coord_t'(req.r);
              f_nxt     = EW'(1) - EW'(req.r);
              ddx_nxt   = EW'(1);
              ddy_nxt   = -(EW'(req.r) <<< 1);
              k_nxt     = '0;
              state_nxt = mfre_pkg::W_CPTS;
            end
            mfre_pkg::CMD_DISC: state_nxt = mfre_pkg::W_DSET;
            default: ;
          endcase
        end
      end
      mfre_pkg::W_PIXEL: begin
        if (take) state_nxt = mfre_pkg::W_IDLE;
      end
      mfre_pkg::W_LSET: begin
        x_nxt     = la_x;
        y_nxt     = la_y;
        xb_nxt    = lb_x;
        yb_nxt    = lb_y;
        dx_nxt    = (ldx < 0) ? -EW'(ldx) : EW'(ldx);
        dy_nxt    = (ldy < 0) ? EW'(ldy) : -EW'(ldy);
        err_nxt   = ((ldx < 0) ? -EW'(ldx) : EW'(ldx)) +
                    ((ldy < 0) ? EW'(ldy) : -EW'(ldy));
        sxn_nxt   = !(la_x < lb_x);
        syn_nxt   = !(la_y < lb_y);
        state_nxt = mfre_pkg::W_LRUN;
      end
      mfre_pkg::W_LRUN: begin
        if (take) begin
          if (x_r == xb_r && y_r == yb_r) begin
            if (seg_r == last_seg_r) begin
              state_nxt = mfre_pkg::W_IDLE;
            end else begin
              seg_nxt   = seg_r + 2'd1;
              state_nxt = mfre_pkg::W_LSET;
            end
          end else begin
            err_nxt = err_r + (cond_x ? dy_r : '0) + (cond_y ? dx_r : '0);
            if (cond_x) x_nxt = sxn_r ? x_r - C_ONE : x_r + C_ONE;
            if (cond_y) y_nxt = syn_r ? y_r - C_ONE : y_r + C_ONE;
          end
        end
      end
      mfre_pkg::W_FSET: begin
        xl_nxt = f_xl;
        xh_nxt = f_xh;
        yl_nxt = f_yl;
        yh_nxt = f_yh;
        x_nxt  = f_xl;
        y_nxt  = f_yl;
        state_nxt = (f_xl > f_xh || f_yl > f_yh) ? mfre_pkg::W_IDLE : mfre_pkg::W_FRUN;
      end
      mfre_pkg::W_FRUN: begin
        if (take) begin
          if (x_r == xh_r) begin
            x_nxt = xl_r;
            if (y_r == yh_r) state_nxt = mfre_pkg::W_IDLE;
            else y_nxt = y_r + C_ONE;
          end else begin
            x_nxt = x_r + C_ONE;
          end
        end
      end
      mfre_pkg::W_CPTS: begin
        if (take) begin
          k_nxt = k_r + 3'd1;
          if (k_r == 3'd7) state_nxt = mfre_pkg::W_CSTEP;
        end
      end
      mfre_pkg::W_CSTEP: begin
        if (x_r < y_r) begin
          if (f_r >= 0) y_nxt = y_r - C_ONE;
          ddy_nxt   = c_ddy;
          ddx_nxt   = c_ddx;
          f_nxt     = c_f1 + c_ddx;
          x_nxt     = x_r + C_ONE;
          k_nxt     = '0;
          state_nxt = mfre_pkg::W_CPTS;
        end else begin
          state_nxt = mfre_pkg::W_IDLE;
        end
      end
      mfre_pkg::W_DSET: begin
        rr_nxt    = sq;
        xl_nxt    = d_xl;
        xh_nxt    = d_xh;
        yl_nxt    = d_yl;
        yh_nxt    = d_yh;
        state_nxt = mfre_pkg::W_DCHK;
      end
      mfre_pkg::W_DCHK: begin
        state_nxt = (xl_r > xh_r || yl_r > yh_r) ? mfre_pkg::W_IDLE : mfre_pkg::W_DSQY;
      end
      mfre_pkg::W_DSQY: begin
        ysq_nxt   = sq;
        state_nxt = mfre_pkg::W_DSQX;
      end
      mfre_pkg::W_DSQX: begin
        xlsq_nxt  = sq;
        xsq_nxt   = sq;
        x_nxt     = xl_r;
        y_nxt     = yl_r;
        state_nxt = mfre_pkg::W_DRUN;
      end
      mfre_pkg::W_DRUN: begin
        if (!in_disc || take) begin
          if (x_r == xh_r) begin
            if (y_r == yh_r) begin
              state_nxt = mfre_pkg::W_IDLE;
            end else begin
              y_nxt   = y_r + C_ONE;
              ysq_nxt = ysq_r + sq_step(y_r);
              x_nxt   = xl_r;
              xsq_nxt = xlsq_r;
            end
          end else begin
            x_nxt   = x_r + C_ONE;
            xsq_nxt = xsq_r + sq_step(x_r);
          end
        end
      end
      default: state_nxt = mfre_pkg::W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfre_pkg::W_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;  y_r <= y_nxt;  xb_r <= xb_nxt;  yb_r <= yb_nxt;
    ax_r <= ax_nxt;  ay_r <= ay_nxt;  ex_r <= ex_nxt;  ey_r <= ey_nxt;
    xl_r <= xl_nxt;  xh_r <= xh_nxt;  yl_r <= yl_nxt;  yh_r <= yh_nxt;
    dx_r <= dx_nxt;  dy_r <= dy_nxt;  err_r <= err_nxt;
    f_r <= f_nxt;  ddx_r <= ddx_nxt;  ddy_r <= ddy_nxt;
    sxn_r <= sxn_nxt;  syn_r <= syn_nxt;  line_r <= line_nxt;
    seg_r <= seg_nxt;  last_seg_r <= last_seg_nxt;  k_r <= k_nxt;  rad_r <= rad_nxt;
    rr_r <= rr_nxt;  xsq_r <= xsq_nxt;  ysq_r <= ysq_nxt;  xlsq_r <= xlsq_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/monochrome_framebuffer_raster_engine.sv -----
// Monochrome framebuffer raster engine: a 1-bit-per-pixel framebuffer, MSB first
// in each byte, drawn into by commands arriving on the in_ch request channel.
// Each accepted request yields exactly one result on out_ch, carrying the echoed
// command, the mirrored byte for a read and the out-of-range flag.
// Drawing commands are turned into pixels by a shape walker; every on-panel
// pixel is a read-modify-write of the frame memory, and an off-panel pixel is
// dropped. A clear sweeps the memory, one byte per cycle, over all
// ROW_BYTES * PANEL_HEIGHT bytes (48000 at the default size); a read's result
// passes through the memory's registered read port, a result register and the
// output register. One request is worked on at a time; the single memory port
// pair sets the rate.
// After reset the memory is filled with white by a clearing pass over all
// ROW_BYTES * PANEL_HEIGHT bytes, during which in_ch.ready stays low.
// Results are held in an output register; if the receiver stalls, the finished
// request waits there, one further request may still be taken and worked on,
// and then the input stays closed until the held result leaves.
`default_nettype none

module monochrome_framebuffer_raster_engine #(
  parameter int PANEL_WIDTH  = mfre_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = mfre_pkg::DEF_PANEL_HEIGHT
) (
  input wire logic    clk,
  input wire logic    rst_n,
  mfre_in_if.sink     in_ch,
  mfre_out_if.source  out_ch
);

  localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
  localparam int DEPTH     = ROW_BYTES * PANEL_HEIGHT;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mfre_pkg::top_state_t state_r, state_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt, waddr_r, waddr_nxt;
  logic rmw_pend_r, rmw_pend_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] mask_r, mask_nxt, fill_r, fill_nxt;
  logic [7:0] res_byte_r, res_byte_nxt, out_byte_r, out_byte_nxt;
  logic res_oor_r, res_oor_nxt, out_oor_r, out_oor_nxt, ink_r, ink_nxt;
  logic [2:0] cmd_r, cmd_nxt, out_cmd_r, out_cmd_nxt;

  mfre_pkg::cmd_t      in_cmd;
  mfre_pkg::draw_req_t req;
  mfre_pkg::px_t       wk_px;
  logic wk_start, wk_take, accept, rd_oor, px_on, slot_free, sweep_end;
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, px_addr, rd_addr;
  logic [7:0] ram_wdata, ram_rdata;

  mfre_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mfre_walker #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (wk_start),
    .req   (req),
    .take  (wk_take),
    .px    (wk_px)
  );

  // Request decode, clipping and address arithmetic.
  always_comb begin
    in_cmd    = mfre_pkg::cmd_t'(in_ch.cmd);
    accept    = in_ch.valid && in_ch.ready;
    req.cmd   = in_cmd;
    req.xs    = in_ch.x_start;
    req.ys    = in_ch.y_start;
    req.xe    = in_ch.x_end;
    req.ye    = in_ch.y_end;
    req.w     = in_ch.rect_width;
    req.h     = in_ch.rect_height;
    req.r     = in_ch.radius;
    rd_oor    = (int'(in_ch.read_row) >= PANEL_HEIGHT) ||
                (int'(in_ch.read_column) >= ROW_BYTES);
    rd_addr   = AW'(AW'(in_ch.read_row) * AW'(ROW_BYTES)) + AW'(ROW_BYTES - 1) -
                AW'(in_ch.read_column);
    px_on     = (wk_px.x >= 0) && (wk_px.x < mfre_pkg::coord_t'(PANEL_WIDTH)) &&
                (wk_px.y >= 0) && (wk_px.y < mfre_pkg::coord_t'(PANEL_HEIGHT));
    px_addr   = AW'(AW'(wk_px.y) * AW'(ROW_BYTES)) + AW'(wk_px.x[mfre_pkg::CW-1:3]);
    slot_free = !out_valid_r || out_ch.ready;
    sweep_end = (sweep_r == AW'(DEPTH - 1));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mfre_pkg::T_INIT:  if (sweep_end) state_nxt = mfre_pkg::T_IDLE;
      mfre_pkg::T_IDLE: begin
        if (accept) begin
          case (in_cmd)
            mfre_pkg::CMD_CLEAR: state_nxt = mfre_pkg::T_CLEAR;
            mfre_pkg::CMD_READ:  state_nxt = rd_oor ? mfre_pkg::T_DONE : mfre_pkg::T_READ;
            default:             state_nxt = mfre_pkg::T_DRAW;
          endcase
        end
      end
      mfre_pkg::T_CLEAR: if (sweep_end) state_nxt = mfre_pkg::T_DONE;
      mfre_pkg::T_READ:  state_nxt = mfre_pkg::T_DONE;
      mfre_pkg::T_DRAW: begin
        if (!rmw_pend_r && !wk_px.valid && !wk_px.busy) state_nxt = mfre_pkg::T_DONE;
      end
      mfre_pkg::T_DONE:  if (slot_free) state_nxt = mfre_pkg::T_IDLE;
      default:           state_nxt = mfre_pkg::T_IDLE;
    endcase
  end

  // Memory port, walker handshake and channel outputs.
  always_comb begin
    in_ch.ready = (state_r == mfre_pkg::T_IDLE);
    wk_start    = accept && (in_cmd != mfre_pkg::CMD_CLEAR) &&
                  (in_cmd != mfre_pkg::CMD_READ);
    wk_take     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = sweep_r;
    ram_wdata   = (state_r == mfre_pkg::T_INIT) ? mfre_pkg::BYTE_WHITE : fill_r;
    ram_raddr   = (state_r == mfre_pkg::T_IDLE) ? rd_addr : px_addr;
    case (state_r)
      mfre_pkg::T_INIT, mfre_pkg::T_CLEAR: ram_we = 1'b1;
      mfre_pkg::T_DRAW: begin
        if (rmw_pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = waddr_r;
          ram_wdata = ink_r ? (ram_rdata | mask_r) : (ram_rdata & ~mask_r);
          wk_take   = 1'b1;
        end else if (wk_px.valid && !px_on) begin
          wk_take = 1'b1;
        end
      end
      default: ;
    endcase
    out_ch.valid             = out_valid_r;
    out_ch.read_byte         = out_byte_r;
    out_ch.read_out_of_range = out_oor_r;
    out_ch.done_cmd          = out_cmd_r;
  end

  // Register updates.
  always_comb begin
    sweep_nxt     = sweep_r;
    rmw_pend_nxt  = rmw_pend_r;
    out_valid_nxt = out_valid_r;
    waddr_nxt     = waddr_r;
    mask_nxt      = mask_r;
    fill_nxt      = fill_r;
    ink_nxt       = ink_r;
    cmd_nxt       = cmd_r;
    res_byte_nxt  = res_byte_r;
    res_oor_nxt   = res_oor_r;
    out_byte_nxt  = out_byte_r;
    out_oor_nxt   = out_oor_r;
    out_cmd_nxt   = out_cmd_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    case (state_r)
      mfre_pkg::T_INIT, mfre_pkg::T_CLEAR: sweep_nxt = sweep_r + 1'b1;
      mfre_pkg::T_IDLE: begin
        if (accept) begin
          sweep_nxt    = '0;
          ink_nxt      = in_ch.ink;
          fill_nxt     = in_ch.ink ? mfre_pkg::BYTE_WHITE : mfre_pkg::BYTE_BLACK;
          cmd_nxt      = in_ch.cmd;
          res_byte_nxt = '0;
          res_oor_nxt  = (in_cmd == mfre_pkg::CMD_READ) && rd_oor;
        end
      end
      mfre_pkg::T_READ: res_byte_nxt = mfre_pkg::flip_byte(ram_rdata);
      mfre_pkg::T_DRAW: begin
        if (rmw_pend_r) begin
          rmw_pend_nxt = 1'b0;
        end else if (wk_px.valid && px_on) begin
          rmw_pend_nxt = 1'b1;
          waddr_nxt    = px_addr;
          mask_nxt     = mfre_pkg::PIXEL_MSB >> wk_px.x[2:0];
        end
      end
      mfre_pkg::T_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = res_byte_r;
          out_oor_nxt   = res_oor_r;
          out_cmd_nxt   = cmd_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfre_pkg::T_INIT;
      sweep_r     <= '0;
      rmw_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      rmw_pend_r  <= rmw_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    waddr_r    <= waddr_nxt;
    mask_r     <= mask_nxt;
    fill_r     <= fill_nxt;
    ink_r      <= ink_nxt;
    cmd_r      <= cmd_nxt;
    res_byte_r <= res_byte_nxt;
    res_oor_r  <= res_oor_nxt;
    out_byte_r <= out_byte_nxt;
    out_oor_r  <= out_oor_nxt;
    out_cmd_r  <= out_cmd_nxt;
  end

  // A write-back while drawing always follows the read of the same pixel.
  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfre_pkg::T_DRAW && rmw_pend_r) |->
      $past(state_r == mfre_pkg::T_DRAW && !rmw_pend_r && wk_px.valid))
    else $error("write-back without a preceding read");

  // The walker is quiet whenever a new request may be taken.
  a_walker_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfre_pkg::T_IDLE) |-> !wk_px.busy)
    else $error("walker busy while idle");

  // An accepted request closes the input until its result is issued.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("second request taken while one is in progress");

  // A pixel is taken only when offered.
  a_take_offered: assert property (@(posedge clk) disable iff (!rst_n)
    wk_take |-> wk_px.valid)
    else $error("pixel taken that was not offered");

endmodule

`default_nettype wire
